[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/b58_pkg.sv]
// ---------------------------------------------------------------------------
// Base58 codec package
// Shared constants, the digit step result type and the alphabet functions.
// ---------------------------------------------------------------------------
package b58_pkg;

  // Default sizes of a message and of the digit store.
  localparam int unsigned MaxSymbolsDef = 32;
  localparam int unsigned DigitDepthDef = 45;
  // Largest number of results a message may produce.
  localparam int unsigned MaxResults    = 44;

  // Payload widths.
  localparam int unsigned SymW   = 8;
  localparam int unsigned DigitW = 8;
  // The carry stays at or below 1146 in either direction.
  localparam int unsigned CarryW = 11;
  // Widest value formed in one digit step (carry plus 256 times a digit).
  localparam int unsigned AccW   = 17;

  // Base58 radix and the reciprocal that divides a value below 2**17 by it.
  localparam int unsigned Radix      = 58;
  localparam int unsigned RecipW     = 18;
  localparam int unsigned RecipShift = 23;
  localparam int unsigned RecipMul   = 144632;

  // The character that stands for a leading zero byte.
  localparam logic [SymW-1:0] ZeroChar = 8'h31;

  // Outcome of one multiply-and-carry step.
  typedef struct packed {
    logic [DigitW-1:0] digit;
    logic [CarryW-1:0] carry;
  } alu_res_t;

  // Outcome of an alphabet lookup.
  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } letter_t;

  // Maps an ASCII character to its Base58 value.
  function automatic letter_t letter_lookup(input logic [SymW-1:0] ch);
    letter_t res;
    res.valid = 1'b1;
    res.value = '0;
    if (ch >= "1" && ch <= "9") begin
      res.value = 6'(ch - "1");
    end else if (ch >= "A" && ch <= "H") begin
      res.value = 6'(ch - "A" + 8'd9);
    end else if (ch >= "J" && ch <= "N") begin
      res.value = 6'(ch - "J" + 8'd17);
    end else if (ch >= "P" && ch <= "Z") begin
      res.value = 6'(ch - "P" + 8'd22);
    end else if (ch >= "a" && ch <= "k") begin
      res.value = 6'(ch - "a" + 8'd33);
    end else if (ch >= "m" && ch <= "z") begin
      res.value = 6'(ch - "m" + 8'd44);
    end else begin
      res.valid = 1'b0;
    end
    return res;
  endfunction

  // Maps a Base58 digit to its character; a digit above the alphabet gives '1'.
  function automatic logic [SymW-1:0] digit_to_char(input logic [DigitW-1:0] d);
    logic [SymW-1:0] ch;
    if (d < 8'd9) begin
      ch = "1" + d;
    end else if (d < 8'd17) begin
      ch = "A" + d - 8'd9;
    end else if (d < 8'd22) begin
      ch = "J" + d - 8'd17;
    end else if (d < 8'd33) begin
      ch = "P" + d - 8'd22;
    end else if (d < 8'd44) begin
      ch = "a" + d - 8'd33;
    end else if (d < 8'd58) begin
      ch = "m" + d - 8'd44;
    end else begin
      ch = ZeroChar;
    end
    return ch;
  endfunction

endpackage

[hw/rtl/b58_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module b58_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 45
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Synchronous write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hw/rtl/b58_digit_alu.sv]
// ---------------------------------------------------------------------------
// Base58 digit step
// One multiply-and-carry step: times 256 mod 58 when encoding, times 58
// mod 256 when decoding.
// ---------------------------------------------------------------------------
module b58_digit_alu
  import b58_pkg::*;
(
  input  logic              dir_i,
  input  logic [CarryW-1:0] carry_i,
  input  logic [DigitW-1:0] digit_i,
  output alu_res_t          res_o
);

  logic [AccW-1:0]        x_enc;
  logic [AccW-1:0]        x_dec;
  logic [AccW+RecipW-1:0] prod;
  logic [CarryW-1:0]      q_enc;
  logic [AccW-1:0]        r_enc;

  // Encoding: x = carry + 256 * digit, divided by 58 through the reciprocal.
  assign x_enc = AccW'(carry_i) + (AccW'(digit_i) << 8);
  assign prod  = (AccW+RecipW)'(x_enc) * (AccW+RecipW)'(RecipMul);
  assign q_enc = prod[RecipShift +: CarryW];
  assign r_enc = x_enc - AccW'(q_enc) * AccW'(Radix);

  // Decoding: x = carry + 58 * digit, split at bit 8.
  assign x_dec = AccW'(carry_i) + AccW'(digit_i) * AccW'(Radix);

  always_comb begin
    if (dir_i) begin
      res_o.digit = x_dec[DigitW-1:0];
      res_o.carry = CarryW'(x_dec[AccW-1:DigitW]);
    end else begin
      res_o.digit = r_enc[DigitW-1:0];
      res_o.carry = q_enc;
    end
  end

endmodule

[hw/rtl/base58_codec.sv]
// ---------------------------------------------------------------------------
// Base58 codec
// Converts a message between raw bytes and Base58 text, keeping the number
// in a little-endian digit store in RAM.
// ---------------------------------------------------------------------------
//  Channel   | Direction | Handshake                | Payload
//  ----------+-----------+--------------------------+-------------------------
//  request   | in        | start & !busy            | in_symbol_i, in_last_i
//  result    | out       | result_valid_o, 1 cycle  | out_symbol_o, out_last_o,
//            |           |                          | out_error_o
//  config    | in        | cfg_we_i                 | cfg_wdata_i (direction)
//
// A request in the leading run, or one that is dropped, is handled in ST_IDLE.
// A folded request sweeps the digit positions in ST_FOLD, at most DIGIT_DEPTH of
// them, holding busy; the single RAM read port walks one digit per cycle.
// The last request passes through ST_FINAL, then one result per cycle for the
// leading run and one per cycle for the stored digits, or one error result.
// Reset clears all control state; the digit store needs no clearing pass,
// since a position's contents are used only after it has been written.
// Results cannot be stalled; busy drops in the cycle that shows the last one.
// ---------------------------------------------------------------------------
module base58_codec
  import b58_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = MaxSymbolsDef,
  parameter int unsigned DIGIT_DEPTH = DigitDepthDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [SymW-1:0] in_symbol_i,
  input  logic            in_last_i,
  output logic            result_valid_o,
  output logic [SymW-1:0] out_symbol_o,
  output logic            out_last_o,
  output logic            out_error_o,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i
);

  localparam int unsigned AddrW = $clog2(DIGIT_DEPTH);
  localparam int unsigned CntW  = $clog2(DIGIT_DEPTH + 1);
  localparam int unsigned RunW  = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned TotW  = ((RunW > CntW) ? RunW : CntW) + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FOLD,
    ST_FINAL,
    ST_LEAD,
    ST_DIGIT,
    ST_DRAIN
  } state_e;

  state_e state_q, state_d;

  logic              dir_q, dir_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [RunW-1:0]   run_q, run_d;
  logic [RunW-1:0]   items_q, items_d;
  logic              leading_q, leading_d;
  logic              err_q, err_d;
  logic              last_q, last_d;
  logic [CarryW-1:0] carry_q, carry_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [RunW-1:0]   lead_q, lead_d;
  logic              pend_q, pend_d;
  logic              pend_last_q, pend_last_d;
  logic              res_valid_q, res_valid_d;
  logic [SymW-1:0]   res_symbol_q, res_symbol_d;
  logic              res_last_q, res_last_d;
  logic              res_error_q, res_error_d;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr;
  logic [DigitW-1:0] ram_wdata;
  logic              ram_re;
  logic [AddrW-1:0]  ram_raddr;
  logic [DigitW-1:0] ram_rdata;

  letter_t           letter;
  logic [SymW-1:0]   zero_sym;
  logic              fold_in_range;
  logic              fold_grow;
  logic              fold_more;
  logic [CntW-1:0]   idx_nxt;
  logic [DigitW-1:0] alu_digit;
  alu_res_t          alu_res;
  logic [TotW-1:0]   total;
  logic              final_bad;
  logic [RunW-1:0]   lead_nxt;
  logic              lead_done;
  logic              clear_msg;

  // Digit store.
  b58_ram #(
    .WIDTH (DigitW),
    .DEPTH (DIGIT_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Fold sweep status; a position past the current length reads as zero.
  assign fold_in_range = idx_q < count_q;
  assign fold_grow     = idx_q == count_q;
  assign fold_more     = fold_in_range || (carry_q != '0);
  assign idx_nxt       = idx_q + 1'b1;
  assign alu_digit     = fold_in_range ? ram_rdata : '0;

  b58_digit_alu u_alu (
    .dir_i   (dir_q),
    .carry_i (carry_q),
    .digit_i (alu_digit),
    .res_o   (alu_res)
  );

  // Request decode and end-of-message checks.
  assign letter    = letter_lookup(in_symbol_i);
  assign zero_sym  = dir_q ? ZeroChar : '0;
  assign total     = TotW'(run_q) + TotW'(count_q);
  assign final_bad = err_q || (32'(total) > MaxResults) || (total == '0);
  assign lead_nxt  = lead_q + 1'b1;
  assign lead_done = lead_nxt == run_q;

  assign busy           = state_q != ST_IDLE;
  assign result_valid_o = res_valid_q;
  assign out_symbol_o   = res_symbol_q;
  assign out_last_o     = res_last_q;
  assign out_error_o    = res_error_q;

  // Next-state logic for the sequencer, the message state and the results.
  always_comb begin
    state_d      = state_q;
    dir_d        = cfg_we_i ? cfg_wdata_i : dir_q;
    count_d      = count_q;
    run_d        = run_q;
    items_d      = items_q;
    leading_d    = leading_q;
    err_d        = err_q;
    last_d       = last_q;
    carry_d      = carry_q;
    idx_d        = idx_q;
    lead_d       = lead_q;
    pend_d       = 1'b0;
    pend_last_d  = 1'b0;
    res_valid_d  = 1'b0;
    res_symbol_d = res_symbol_q;
    res_last_d   = res_last_q;
    res_error_d  = res_error_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q[AddrW-1:0];
    ram_wdata    = alu_res.digit;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    clear_msg    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          last_d  = in_last_i;
          state_d = in_last_i ? ST_FINAL : ST_IDLE;
          if (32'(items_q) >= MAX_SYMBOLS) begin
            err_d = 1'b1;
          end else begin
            items_d = items_q + 1'b1;
            if (!err_q) begin
              if (leading_q && (in_symbol_i == zero_sym)) begin
                run_d = run_q + 1'b1;
              end else begin
                leading_d = 1'b0;
                if (dir_q && !letter.valid) begin
                  err_d = 1'b1;
                end else begin
                  // Start the sweep: fetch the least significant digit.
                  carry_d   = dir_q ? CarryW'(letter.value) : CarryW'(in_symbol_i);
                  idx_d     = '0;
                  ram_re    = 1'b1;
                  ram_raddr = '0;
                  state_d   = ST_FOLD;
                end
              end
            end
          end
        end
      end

      ST_FOLD: begin
        if (!fold_more) begin
          state_d = last_q ? ST_FINAL : ST_IDLE;
        end else if (fold_grow && (32'(count_q) >= DIGIT_DEPTH)) begin
          // The store is full and a carry is left over.
          err_d   = 1'b1;
          state_d = last_q ? ST_FINAL : ST_IDLE;
        end else begin
          if (fold_grow) begin
            count_d = count_q + 1'b1;
          end
          ram_we  = 1'b1;
          carry_d = alu_res.carry;
          idx_d   = idx_nxt;
          // Fetch the next position while this one is written back.
          if (32'(idx_nxt) < DIGIT_DEPTH) begin
            ram_re    = 1'b1;
            ram_raddr = idx_nxt[AddrW-1:0];
          end
        end
      end

      ST_FINAL: begin
        if (final_bad) begin
          res_valid_d  = 1'b1;
          res_symbol_d = '0;
          res_last_d   = 1'b1;
          res_error_d  = 1'b1;
          clear_msg    = 1'b1;
          state_d      = ST_IDLE;
        end else if (run_q != '0) begin
          lead_d  = '0;
          state_d = ST_LEAD;
        end else begin
          idx_d   = count_q - 1'b1;
          state_d = ST_DIGIT;
        end
      end

      ST_LEAD: begin
        res_valid_d  = 1'b1;
        res_symbol_d = dir_q ? '0 : ZeroChar;
        res_last_d   = lead_done && (count_q == '0);
        res_error_d  = 1'b0;
        lead_d       = lead_nxt;
        if (lead_done) begin
          if (count_q == '0) begin
            clear_msg = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            idx_d   = count_q - 1'b1;
            state_d = ST_DIGIT;
          end
        end
      end

      ST_DIGIT: begin
        // Read digits from the most significant down; the store registers the read data.
        ram_re      = 1'b1;
        ram_raddr   = idx_q[AddrW-1:0];
        pend_d      = 1'b1;
        pend_last_d = idx_q == '0;
        if (idx_q == '0) begin
          state_d = ST_DRAIN;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end

      ST_DRAIN: begin
        clear_msg = 1'b1;
        state_d   = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Output stage for digits read from the store.
    if (pend_q) begin
      res_valid_d  = 1'b1;
      res_symbol_d = dir_q ? ram_rdata : digit_to_char(ram_rdata);
      res_last_d   = pend_last_q;
      res_error_d  = 1'b0;
    end

    // Return the message state to its idle values after the last request.
    if (clear_msg) begin
      count_d   = '0;
      run_d     = '0;
      items_d   = '0;
      leading_d = 1'b1;
      err_d     = 1'b0;
    end
  end

  // State, message registers and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      dir_q        <= 1'b0;
      count_q      <= '0;
      run_q        <= '0;
      items_q      <= '0;
      leading_q    <= 1'b1;
      err_q        <= 1'b0;
      last_q       <= 1'b0;
      carry_q      <= '0;
      idx_q        <= '0;
      lead_q       <= '0;
      pend_q       <= 1'b0;
      pend_last_q  <= 1'b0;
      res_valid_q  <= 1'b0;
      res_symbol_q <= '0;
      res_last_q   <= 1'b0;
      res_error_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      dir_q        <= dir_d;
      count_q      <= count_d;
      run_q        <= run_d;
      items_q      <= items_d;
      leading_q    <= leading_d;
      err_q        <= err_d;
      last_q       <= last_d;
      carry_q      <= carry_d;
      idx_q        <= idx_d;
      lead_q       <= lead_d;
      pend_q       <= pend_d;
      pend_last_q  <= pend_last_d;
      res_valid_q  <= res_valid_d;
      res_symbol_q <= res_symbol_d;
      res_last_q   <= res_last_d;
      res_error_q  <= res_error_d;
    end
  end

endmodule

[hw/rtl/base58_codec_chk.sv]
// ---------------------------------------------------------------------------
// Base58 codec checker
// Port-level assertions on the result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module base58_codec_chk
  import b58_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            start,
  input logic            busy,
  input logic            result_valid_o,
  input logic [SymW-1:0] out_symbol_o,
  input logic            out_last_o,
  input logic            out_error_o
);

  logic req_acc;

  assign req_acc = start && !busy;

  // An error result is the whole answer and carries no symbol.
  `ASSERT_IMPLY(err_is_single, clk_i, rst_ni, result_valid_o && out_error_o, out_last_o && (out_symbol_o == '0), "error result must be last with a zero symbol")

  // Results before the last one come while the block is still busy.
  `ASSERT_IMPLY(mid_while_busy, clk_i, rst_ni, result_valid_o && !out_last_o, busy, "non-final result shown while idle")

  // The block is free again when the last result shows.
  `ASSERT_IMPLY(last_frees, clk_i, rst_ni, result_valid_o && out_last_o, !busy, "busy still high at the last result")

  // No result directly follows the last one, even if a request is taken.
  `ASSERT_NEXT(gap_after_last, clk_i, rst_ni, result_valid_o && out_last_o && req_acc, !result_valid_o, "result right after the last result")

endmodule

bind base58_codec base58_codec_chk u_chk (.*);

[test/tb.sv]
// ----------------------------------------------------------------------------
// Base58 codec testbench
// Sends byte and text messages through the codec in both directions. Each
// request is folded into a local digit-store model as it is accepted, and every
// emitted symbol is compared in order against the characters or bytes the
// model says the message must produce.
// ----------------------------------------------------------------------------
module tb;
  import b58_pkg::*;

  localparam int unsigned MaxSymbols  = 32;
  localparam int unsigned DigitDepth  = 45;
  localparam int unsigned ByteRadix   = 256;
  localparam int unsigned MaxGap      = 5;
  localparam int unsigned RandomItems = 10;
  // A folded request sweeps at most DigitDepth positions plus overhead.
  localparam int unsigned DrainCycles = DigitDepth + 20;
  localparam int unsigned BufDepth    = MaxSymbols + 8;

  // Values of the direction register.
  localparam logic DirEncode = 1'b0;
  localparam logic DirDecode = 1'b1;

  // Base58 letters, digit 0 in the leftmost character.
  localparam logic [8*58-1:0] Alphabet =
    "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

  typedef enum int unsigned {KindClean, KindBadChar, KindOverlong, KindSwitch} msg_kind_e;

  typedef struct packed {
    logic [SymW-1:0] symbol;
    logic            last;
    logic            err;
  } result_t;

  logic            clk_i;
  logic            rst_ni;
  logic            start;
  logic            busy;
  logic [SymW-1:0] in_symbol_i;
  logic            in_last_i;
  logic            result_valid_o;
  logic [SymW-1:0] out_symbol_o;
  logic            out_last_o;
  logic            out_error_o;
  logic            cfg_we_i;
  logic            cfg_wdata_i;

  // Symbols the codec still owes, oldest first.
  result_t expected_out[$];

  // Local copy of the codec state.
  logic [7:0]  digits [DigitDepth];
  int unsigned ndigits;
  int unsigned lead_run;
  int unsigned seen;
  logic        leading;
  logic        bad_msg;
  logic        model_dir;

  // Message buffer shared by the tests.
  logic [SymW-1:0] msg_buf [BufDepth];
  int unsigned     msg_len;

  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned requests_sent;
  int unsigned messages_sent;
  int unsigned error_results;
  int unsigned random_items;

  base58_codec #(
    .MAX_SYMBOLS (MaxSymbols),
    .DIGIT_DEPTH (DigitDepth)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .in_symbol_i    (in_symbol_i),
    .in_last_i      (in_last_i),
    .result_valid_o (result_valid_o),
    .out_symbol_o   (out_symbol_o),
    .out_last_o     (out_last_o),
    .out_error_o    (out_error_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  // Free-running clock, period 10.
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [SymW-1:0] b58_char(input int unsigned d);
    return Alphabet[8*(Radix-1-d) +: 8];
  endfunction

  // Returns the digit value of a character, or -1 outside the alphabet.
  function automatic int letter_index(input logic [SymW-1:0] ch);
    for (int k = 0; k < Radix; k++) begin
      if (b58_char(k) == ch) return k;
    end
    return -1;
  endfunction

  function automatic void clear_message();
    ndigits  = 0;
    lead_run = 0;
    seen     = 0;
    leading  = 1'b1;
    bad_msg  = 1'b0;
  endfunction

  // Appends one symbol to the list of symbols still owed.
  function automatic void queue_result(input result_t r);
    expected_out.insert(expected_out.size(), r);
  endfunction

  // Multiplies the stored number by mult and adds carry, digits in base radix.
  function automatic void fold_value(input int unsigned carry, input int unsigned mult,
                                     input int unsigned radix);
    int unsigned j;
    j = 0;
    while (j < ndigits || carry != 0) begin
      if (j == ndigits) begin
        // The number no longer fits in the digit store.
        if (ndigits >= DigitDepth) begin
          bad_msg = 1'b1;
          return;
        end
        digits[j] = '0;
        ndigits++;
      end
      carry += mult * digits[j];
      digits[j] = 8'(carry % radix);
      carry /= radix;
      j++;
    end
  endfunction

  // Updates the local state for one accepted request and queues what it emits.
  function automatic void predict_request(input logic [SymW-1:0] sym, input logic last);
    logic [SymW-1:0] zero_sym;
    logic [SymW-1:0] d;
    int              v;
    int unsigned     total;
    int unsigned     n;
    result_t         r;

    // Requests past the message limit only poison the message.
    if (seen >= MaxSymbols) begin
      bad_msg = 1'b1;
    end else begin
      seen++;
      if (!bad_msg) begin
        zero_sym = (model_dir == DirDecode) ? ZeroChar : 8'h00;
        if (leading && sym == zero_sym) begin
          lead_run++;
        end else begin
          leading = 1'b0;
          if (model_dir == DirDecode) begin
            v = letter_index(sym);
            if (v < 0) bad_msg = 1'b1;
            else fold_value(v, Radix, ByteRadix);
          end else begin
            fold_value(sym, ByteRadix, Radix);
          end
        end
      end
    end
    if (!last) return;

    total = lead_run + ndigits;
    if (bad_msg || total > MaxResults || total == 0) begin
      r.symbol = '0;
      r.last   = 1'b1;
      r.err    = 1'b1;
      queue_result(r);
      error_results++;
    end else begin
      n = 0;
      r.err = 1'b0;
      // Leading run first, then digits from the most significant one.
      for (int unsigned k = 0; k < lead_run; k++) begin
        r.symbol = (model_dir == DirDecode) ? 8'h00 : ZeroChar;
        r.last   = (n == total - 1);
        queue_result(r);
        n++;
      end
      for (int unsigned k = ndigits; k > 0; k--) begin
        d = digits[k-1];
        if (model_dir == DirDecode) r.symbol = d;
        else r.symbol = (d < Radix) ? b58_char(d) : ZeroChar;
        r.last = (n == total - 1);
        queue_result(r);
        n++;
      end
    end
    messages_sent++;
    clear_message();
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  // Every shown result is compared with the oldest expected one.
  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_out.size() == 0) begin
        report($sformatf("unexpected result symbol %02h last %0b error %0b",
                         out_symbol_o, out_last_o, out_error_o));
      end else begin
        want = expected_out.pop_front();
        results_checked++;
        if (out_symbol_o !== want.symbol)
          report($sformatf("symbol %02h, expected %02h", out_symbol_o, want.symbol));
        if (out_last_o !== want.last)
          report($sformatf("last flag %0b, expected %0b", out_last_o, want.last));
        if (out_error_o !== want.err)
          report($sformatf("error flag %0b, expected %0b", out_error_o, want.err));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Presents one request after a gap and waits until the codec takes it.
  task automatic send_symbol(input logic [SymW-1:0] sym, input logic last,
                             input int unsigned gap);
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start       <= 1'b1;
    in_symbol_i <= sym;
    in_last_i   <= last;
    do @(posedge clk_i); while (busy);
    requests_sent++;
    predict_request(sym, last);
  endtask

  task automatic release_start();
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic wait_results();
    while (expected_out.size() != 0) @(posedge clk_i);
  endtask

  // Writes the direction once the codec has gone quiet.
  task automatic set_direction(input logic dir);
    release_start();
    wait_results();
    repeat (DrainCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= dir;
    @(negedge clk_i);
    cfg_we_i  <= 1'b0;
    model_dir = dir;
  endtask

  // Sends msg_buf entries first..stop-1; the last flag marks entry msg_len-1.
  task automatic send_range(input int unsigned first, input int unsigned stop,
                            input logic no_gaps);
    for (int unsigned k = first; k < stop; k++) begin
      send_symbol(msg_buf[k], k == msg_len - 1, no_gaps ? 0 : $urandom_range(0, MaxGap));
    end
  endtask

  function automatic logic [SymW-1:0] zero_symbol();
    return (model_dir == DirDecode) ? ZeroChar : 8'h00;
  endfunction

  function automatic logic [SymW-1:0] clean_symbol();
    if (model_dir == DirDecode) return b58_char($urandom_range(0, Radix - 1));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [SymW-1:0] bad_char();
    logic [SymW-1:0] c;
    c = 8'($urandom_range(0, 255));
    while (letter_index(c) >= 0) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Loads a short fixed message given as a packed string, first char leftmost.
  task automatic load_text(input logic [8*8-1:0] text, input int unsigned len);
    for (int unsigned k = 0; k < len; k++) msg_buf[k] = text[8*(len-1-k) +: 8];
    msg_len = len;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Encoding straight out of reset: single bytes, leading zeros, extreme values.
  task automatic test_encode_basic();
    load_text(8'h00, 1);              send_range(0, msg_len, 1'b0);
    load_text(8'hFF, 1);              send_range(0, msg_len, 1'b1);
    load_text({8'h00, 8'h00, 8'h01}, 3); send_range(0, msg_len, 1'b0);
    load_text({8'h80, 8'h7F}, 2);     send_range(0, msg_len, 1'b1);
  endtask

  // Decoding: leading ones, alphabet ends and invalid characters.
  task automatic test_decode_basic();
    set_direction(DirDecode);
    load_text("1", 1);   send_range(0, msg_len, 1'b0);
    load_text("z", 1);   send_range(0, msg_len, 1'b1);
    load_text("11z", 3); send_range(0, msg_len, 1'b0);
    load_text("5Q", 2);  send_range(0, msg_len, 1'b0);
    // A NUL, a zero digit, a high byte and a look-alike letter are rejected.
    load_text(8'h00, 1); send_range(0, msg_len, 1'b0);
    load_text("203", 3); send_range(0, msg_len, 1'b1);
    load_text(8'hFF, 1); send_range(0, msg_len, 1'b0);
    load_text("aIl", 3); send_range(0, msg_len, 1'b0);
  endtask

  // Direction flipped between requests of one message.
  task automatic test_direction_switch();
    // Decoded digits, then a final byte folded as an encoder.
    load_text({"zzz", 8'h00}, 4);
    send_range(0, 3, 1'b0);
    set_direction(DirEncode);
    send_range(3, 4, 1'b0);
    // Encoder digits, then a final text character.
    load_text({8'hFF, "z"}, 2);
    send_range(0, 1, 1'b0);
    set_direction(DirDecode);
    send_range(1, 2, 1'b0);
    // Leading run that spans both directions.
    set_direction(DirEncode);
    load_text({8'h00, "1"}, 2);
    send_range(0, 1, 1'b0);
    set_direction(DirDecode);
    send_range(1, 2, 1'b0);
  endtask

  // Full-length messages and messages one or more requests too long.
  task automatic test_long_messages();
    set_direction(DirEncode);
    for (int unsigned k = 0; k < MaxSymbols; k++) msg_buf[k] = 8'hFF;
    msg_len = MaxSymbols;
    send_range(0, msg_len, 1'b1);
    msg_len = MaxSymbols + 1;
    for (int unsigned k = 0; k < msg_len; k++) msg_buf[k] = clean_symbol();
    send_range(0, msg_len, 1'b0);
    set_direction(DirDecode);
    for (int unsigned k = 0; k < MaxSymbols; k++) msg_buf[k] = ZeroChar;
    msg_len = MaxSymbols;
    send_range(0, msg_len, 1'b1);
    msg_len = MaxSymbols + 2;
    for (int unsigned k = 0; k < msg_len; k++) msg_buf[k] = clean_symbol();
    send_range(0, msg_len, 1'b0);
  endtask

  // Mostly well-formed random messages, with bad characters, overlong
  // messages and mid-message direction changes mixed in.
  task automatic test_random();
    int unsigned len;
    int unsigned lead;
    int unsigned cut;
    int unsigned roll;
    msg_kind_e   kind;
    logic        no_gaps;
    while (random_items < RandomItems) begin
      if ($urandom_range(0, 3) == 0) set_direction(1'($urandom_range(0, 1)));
      roll = $urandom_range(0, 99);
      if (roll < 70) kind = KindClean;
      else if (roll < 80) kind = KindBadChar;
      else if (roll < 88) kind = KindOverlong;
      else kind = KindSwitch;

      if (kind == KindOverlong) len = $urandom_range(MaxSymbols + 1, MaxSymbols + 4);
      else if ($urandom_range(0, 7) == 0) len = $urandom_range(11, MaxSymbols);
      else len = $urandom_range(1, 10);
      lead = $urandom_range(0, 3);
      for (int unsigned k = 0; k < len; k++)
        msg_buf[k] = (k < lead) ? zero_symbol() : clean_symbol();
      if (kind == KindBadChar) msg_buf[$urandom_range(0, len - 1)] = bad_char();
      msg_len = len;
      no_gaps = ($urandom_range(0, 3) == 0);

      if (kind == KindSwitch && len > 1) begin
        cut = $urandom_range(1, len - 1);
        send_range(0, cut, no_gaps);
        set_direction(~model_dir);
        send_range(cut, len, no_gaps);
      end else begin
        send_range(0, len, no_gaps);
      end
      random_items += len;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    in_symbol_i = '0;
    in_last_i   = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = 1'b0;
    mismatches      = 0;
    results_checked = 0;
    requests_sent   = 0;
    messages_sent   = 0;
    error_results   = 0;
    random_items    = 0;
    model_dir       = DirEncode;
    for (int k = 0; k < DigitDepth; k++) digits[k] = '0;
    clear_message();

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_encode_basic();
    test_decode_basic();
    test_direction_switch();
    test_long_messages();
    test_random();

    release_start();
    wait_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d messages of %0d requests in both directions.",
             messages_sent, requests_sent);
    $display("%0d symbols checked, %0d of them error results, %0d mismatches.",
             results_checked, error_results, mismatches);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("timeout with %0d symbols still expected", expected_out.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule
